FILE: design/clist_pkg.sv
// Shared types and constants for the cursor list engine.
package clist_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int ADDR_W   = 6;
    localparam int LIMIT_W  = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    typedef enum logic [2:0] {
        CMD_INS_BEFORE = 3'd0,
        CMD_INS_AFTER  = 3'd1,
        CMD_GET        = 3'd2,
        CMD_REMOVE     = 3'd3,
        CMD_BEGIN      = 3'd4,
        CMD_END        = 3'd5,
        CMD_NEXT       = 3'd6,
        CMD_PRIOR      = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TAKE,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_FIX,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd                     command;
        logic signed [DATA_W-1:0] value_in;
    } t_in_item;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] value_out;
        logic                     is_empty;
        logic                     is_full;
        logic [COUNT_W-1:0]       entry_count;
        logic [ADDR_W-1:0]        cursor_position;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;       // take in a new command
        logic ptr_ins;     // load shift pointer and insert position
        logic ptr_rm;      // load shift pointer at the cursor
        logic rd_cursor;   // read the entry at the cursor
        logic rd_shift;    // read the source entry of a shift step
        logic wr_shift;    // write the shifted entry and step the pointer
        logic put;         // write the new value, grow the list
        logic take;        // capture read data as the result value
        logic rm_fix;      // shrink the list, fix up the cursor
        logic move;        // move the cursor
        logic set_ok;      // mark the command as successful
        logic load_out;    // load the result register
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic full;
        logic move_ok;
        logic can_next;
        logic ins_shift;
        logic shift_last;
        logic out_free;
    } t_dp_status;

endpackage

FILE: design/cursor_list_engine.sv
// Top level of the cursor list engine: controller plus datapath.
//
// An ordered list of up to 64 signed 32-bit entries with a cursor. Each
// transfer on the input channel carries one command (insert before/after
// the cursor, get, remove, or move the cursor to begin, end, next, prior)
// and produces exactly one result transfer with a success flag, the value
// read or removed, and the list state after the command. Entries sit in a
// single-port-write, single-port-read memory, so an insert or remove moves
// the later entries one at a time, each with a read step and a write step.
// After the deliver step the block returns to its idle step, where it takes
// the next command; a result that the receiver stalls holds the block in
// its deliver step until the output register frees up. One command is in
// flight at a time; a new command is taken while the previous result still
// waits in the output register. The list limit register is written through
// i_cfg_we / i_cfg_data; the user must write it only while the block is
// idle, and the block itself does not enforce this. 0 acts as 1 and values
// above 64 act as 64. No clearing pass is needed after reset.
module cursor_list_engine
    import clist_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    // list limit register
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    t_dp_ctl    ctl;
    t_dp_status status;

    // Sequence each command through decide, shift, write and deliver steps
    clist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_ctl      (ctl)
    );

    // Hold the entries, cursor, count, limit and the result register
    clist_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (ctl),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: design/clist_ctrl.sv
// Command sequencer for the cursor list engine.
module clist_ctrl
    import clist_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_ctl    o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_status.cmd) inside
                    CMD_INS_BEFORE, CMD_INS_AFTER: begin
                        if (i_status.full) begin
                            n_state = S_DONE;
                        end else if (i_status.ins_shift) begin
                            n_state = S_SH_RD;
                        end else begin
                            n_state = S_PUT;
                        end
                    end
                    CMD_GET, CMD_REMOVE: begin
                        n_state = i_status.empty ? S_DONE : S_TAKE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_TAKE: begin
                if (i_status.cmd == CMD_REMOVE) begin
                    n_state = i_status.can_next ? S_SH_RD : S_FIX;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SH_RD: begin
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                if (i_status.shift_last) begin
                    n_state = (i_status.cmd == CMD_REMOVE) ? S_FIX : S_PUT;
                end else begin
                    n_state = S_SH_RD;
                end
            end
            S_PUT: begin
                n_state = S_DONE;
            end
            S_FIX: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.latch = i_in_valid;
            end
            S_EXEC: begin
                case (i_status.cmd) inside
                    CMD_INS_BEFORE, CMD_INS_AFTER: begin
                        o_ctl.ptr_ins = !i_status.full;
                    end
                    CMD_GET: begin
                        o_ctl.rd_cursor = !i_status.empty;
                    end
                    CMD_REMOVE: begin
                        o_ctl.rd_cursor = !i_status.empty;
                        o_ctl.ptr_rm    = !i_status.empty;
                    end
                    default: begin
                        o_ctl.move   = i_status.move_ok;
                        o_ctl.set_ok = i_status.move_ok;
                    end
                endcase
            end
            S_TAKE: begin
                o_ctl.take   = 1'b1;
                o_ctl.set_ok = (i_status.cmd == CMD_GET);
            end
            S_SH_RD: begin
                o_ctl.rd_shift = 1'b1;
            end
            S_SH_WR: begin
                o_ctl.wr_shift = 1'b1;
            end
            S_PUT: begin
                o_ctl.put    = 1'b1;
                o_ctl.set_ok = 1'b1;
            end
            S_FIX: begin
                o_ctl.rm_fix = 1'b1;
                o_ctl.set_ok = 1'b1;
            end
            S_DONE: begin
                o_ctl.load_out = i_status.out_free;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

endmodule

FILE: design/clist_dp.sv
// Entry store, cursor, count, limit register and result register.
module clist_dp
    import clist_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_in_item           i_in_item,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    input  t_dp_ctl            i_ctl,
    output t_dp_status         o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item
);

    logic [DATA_W-1:0] mem [CAPACITY];

    t_cmd                     r_cmd;
    logic signed [DATA_W-1:0] r_value;
    logic [COUNT_W-1:0]       r_count;
    logic [ADDR_W-1:0]        r_cursor;
    logic [LIMIT_W-1:0]       r_limit;
    logic [COUNT_W-1:0]       r_ptr;
    logic [ADDR_W-1:0]        r_pos;
    logic [DATA_W-1:0]        r_rd_data;
    logic                     r_ok;
    logic signed [DATA_W-1:0] r_vout;
    logic                     r_out_valid;
    t_out_item                r_out_item;

    logic [COUNT_W-1:0] eff_limit;
    logic [COUNT_W-1:0] cursor_ext;
    logic [COUNT_W-1:0] cursor_inc;
    logic [COUNT_W-1:0] count_dec;
    logic [COUNT_W-1:0] ptr_src;
    logic [ADDR_W-1:0]  ins_pos;
    logic               is_remove;
    logic               empty;
    logic               full;
    logic               can_next;
    logic               move_ok;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [ADDR_W-1:0]  n_cursor;

    // Clamp the limit into 1..CAPACITY
    always_comb begin
        if (r_limit == '0) begin
            eff_limit = COUNT_W'(1);
        end else if (COUNT_W'(r_limit) > COUNT_W'(CAPACITY)) begin
            eff_limit = COUNT_W'(CAPACITY);
        end else begin
            eff_limit = COUNT_W'(r_limit);
        end
    end

    assign is_remove  = (r_cmd == CMD_REMOVE);
    assign cursor_ext = COUNT_W'(r_cursor);
    assign cursor_inc = cursor_ext + COUNT_W'(1);
    assign count_dec  = r_count - COUNT_W'(1);
    assign empty      = (r_count == '0);
    assign full       = (r_count >= eff_limit);
    assign can_next   = (cursor_inc < r_count);

    always_comb begin
        if (empty) begin
            ins_pos = '0;
        end else if (r_cmd == CMD_INS_AFTER) begin
            ins_pos = cursor_inc[ADDR_W-1:0];
        end else begin
            ins_pos = r_cursor;
        end
    end

    always_comb begin
        case (r_cmd)
            CMD_BEGIN, CMD_END: move_ok = !empty;
            CMD_NEXT:           move_ok = can_next;
            CMD_PRIOR:          move_ok = !empty && (r_cursor != '0);
            default:            move_ok = 1'b0;
        endcase
    end

    // Shift source: one below the target for insert, one above for remove
    assign ptr_src = is_remove ? (r_ptr + COUNT_W'(1)) : (r_ptr - COUNT_W'(1));

    always_comb begin
        o_status.cmd       = r_cmd;
        o_status.empty     = empty;
        o_status.full      = full;
        o_status.move_ok   = move_ok;
        o_status.can_next  = can_next;
        o_status.ins_shift = (r_count != COUNT_W'(ins_pos));
        o_status.out_free  = !r_out_valid || i_out_ready;
        if (is_remove) begin
            o_status.shift_last = ((r_ptr + COUNT_W'(2)) == r_count);
        end else begin
            o_status.shift_last = (r_ptr == (COUNT_W'(r_pos) + COUNT_W'(1)));
        end
    end

    // Memory port control
    assign rd_en   = i_ctl.rd_cursor || i_ctl.rd_shift;
    assign rd_addr = i_ctl.rd_shift ? ptr_src[ADDR_W-1:0] : r_cursor;
    assign wr_en   = i_ctl.wr_shift || i_ctl.put;
    assign wr_addr = i_ctl.put ? r_pos : r_ptr[ADDR_W-1:0];
    assign wr_data = i_ctl.put ? DATA_W'(r_value) : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Cursor update
    always_comb begin
        n_cursor = r_cursor;
        if (i_ctl.put) begin
            n_cursor = r_pos;
        end else if (i_ctl.rm_fix) begin
            if (count_dec == '0) begin
                n_cursor = '0;
            end else if (cursor_ext == count_dec) begin
                n_cursor = r_cursor - ADDR_W'(1);
            end
        end else if (i_ctl.move) begin
            case (r_cmd)
                CMD_BEGIN: n_cursor = '0;
                CMD_END:   n_cursor = count_dec[ADDR_W-1:0];
                CMD_NEXT:  n_cursor = cursor_inc[ADDR_W-1:0];
                CMD_PRIOR: n_cursor = r_cursor - ADDR_W'(1);
                default:   n_cursor = r_cursor;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cursor    <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_cursor <= n_cursor;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_ctl.put) begin
                r_count <= r_count + COUNT_W'(1);
            end else if (i_ctl.rm_fix) begin
                r_count <= count_dec;
            end
            if (i_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd   <= i_in_item.command;
            r_value <= i_in_item.value_in;
            r_ok    <= 1'b0;
            r_vout  <= '0;
        end else begin
            if (i_ctl.set_ok) begin
                r_ok <= 1'b1;
            end
            if (i_ctl.take) begin
                r_vout <= r_rd_data;
            end
        end
        if (i_ctl.ptr_ins) begin
            r_ptr <= r_count;
            r_pos <= ins_pos;
        end else if (i_ctl.ptr_rm) begin
            r_ptr <= cursor_ext;
        end else if (i_ctl.wr_shift) begin
            r_ptr <= is_remove ? (r_ptr + COUNT_W'(1)) : (r_ptr - COUNT_W'(1));
        end
        if (i_ctl.load_out) begin
            r_out_item.ok              <= r_ok;
            r_out_item.value_out       <= r_vout;
            r_out_item.is_empty        <= empty;
            r_out_item.is_full         <= full;
            r_out_item.entry_count     <= r_count;
            r_out_item.cursor_position <= r_cursor;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
